### rtl/bmg_pkg.sv
// bmg_pkg: types, constants and helper functions for the Box-Muller generator.
// Used by box_muller_gaussian_generator; depends on nothing else.
package bmg_pkg;

	localparam int UNIFORM_BITS  = 16;
	localparam int FRACTION_BITS = 12;

	localparam logic [UNIFORM_BITS-1:0] MaxU = {UNIFORM_BITS{1'b1}};

	localparam int ExpW      = $clog2(UNIFORM_BITS);
	localparam int LogW      = ExpW + 30;          // log2 in Q30
	localparam int AccW      = LogW + 27;          // -2 ln u1, before rounding
	localparam int SqW       = AccW;               // radicand width
	localparam int SqrtSteps = (SqW + 1) / 2;
	localparam int RootW     = SqrtSteps;          // r in Q28
	localparam int CW        = RootW + 3;          // CORDIC x/y width
	localparam int DivW      = 25;                 // phase quotient bits
	localparam int MulW      = 33;
	localparam int ProdW     = 2 * MulW;
	localparam int NormShift = 28 - FRACTION_BITS;
	localparam int CfgIdxW   = 8;

	localparam logic [26:0] LnK    = 27'd93032640;   // 2*ln2 in Q26
	localparam logic [29:0] Gain   = 30'd652032874;  // CORDIC gain in Q30
	localparam logic [30:0] TwoPi  = 31'd1686629713; // 2*pi in Q28

	localparam logic [CfgIdxW-1:0] CFG_MEAN  = 8'd0;
	localparam logic [CfgIdxW-1:0] CFG_SCALE = 8'd1;

	localparam logic signed [CW:0] NormHalf  = (CW+1)'(1) << (NormShift - 1);
	localparam logic signed [34:0] ScaleHalf = 35'(1) << (FRACTION_BITS - 1);

	typedef struct packed {
		logic [UNIFORM_BITS-1:0] uniform_radius;
		logic [UNIFORM_BITS-1:0] uniform_angle;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               rejected;
	} out_word_t;

	typedef enum logic [3:0] {
		S_IDLE, S_NORM, S_LOG, S_DIFF, S_LN_LO, S_LN_HI, S_ROOT_LD, S_ROOT,
		S_GAIN, S_ANGLE, S_ROTATE, S_ROUND, S_SCALE, S_DONE
	} bmg_state_t;

	// arctangent of 2^-i in Q28
	function automatic logic [27:0] atan_q28(input logic [3:0] i);
		logic [27:0] v;
		case (i)
			4'd0:    v = 28'd210828714;
			4'd1:    v = 28'd124459457;
			4'd2:    v = 28'd65760959;
			4'd3:    v = 28'd33381290;
			4'd4:    v = 28'd16755422;
			4'd5:    v = 28'd8385879;
			4'd6:    v = 28'd4193963;
			4'd7:    v = 28'd2097109;
			4'd8:    v = 28'd1048571;
			4'd9:    v = 28'd524287;
			4'd10:   v = 28'd262144;
			4'd11:   v = 28'd131072;
			4'd12:   v = 28'd65536;
			4'd13:   v = 28'd32768;
			4'd14:   v = 28'd16384;
			4'd15:   v = 28'd8192;
			default: v = 28'd0;
		endcase
		return v;
	endfunction

	// log2(MaxU) in Q30, same squaring recipe as the hardware; elaboration only
	function automatic logic [LogW-1:0] log2_max();
		logic [63:0]     m;
		logic [LogW-1:0] res;
		int              e;
		e   = UNIFORM_BITS - 1;
		m   = (e <= 30) ? (64'(MaxU) << (30 - e)) : (64'(MaxU) >> (e - 30));
		res = LogW'(e) << 30;
		for (int i = 1; i <= 30; i++) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				res[30-i] = 1'b1;
			end
		end
		return res;
	endfunction

	localparam logic [LogW-1:0] LogMax = log2_max();

	function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
		logic signed [15:0] r;
		if (v > 40'sd32767)
			r = 16'sh7fff;
		else if (v < -40'sd32768)
			r = -16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

	// Q28 value to Q.FRACTION_BITS, round half up, saturate
	function automatic logic signed [15:0] to_normal(input logic signed [CW-1:0] v);
		logic signed [CW:0] t;
		t = {v[CW-1], v} + NormHalf;
		t = t >>> NormShift;
		return sat16(40'(t));
	endfunction

	// scaled product to sample: round, add mean, saturate
	function automatic logic signed [15:0] scale_sample(input logic signed [33:0] p,
		input logic signed [15:0] mu);
		logic signed [34:0] t;
		t = {p[33], p} + ScaleHalf;
		t = t >>> FRACTION_BITS;
		return sat16(40'(t) + 40'(mu));
	endfunction

endpackage

### rtl/box_muller_gaussian_generator.sv
// box_muller_gaussian_generator: fixed-point Box-Muller Gaussian sample generator.
// Depends on bmg_pkg (types, constants, atan table, rounding helpers).
//
// Each word on the input channel carries two uniforms. The first word of a pair
// computes r = sqrt(-2 ln u1) and the angle 2*pi*u2, returns r*cos*sigma + mu and
// keeps r*sin for the next word, which ignores its uniforms and returns the kept
// value scaled the same way. A zero radius uniform with nothing kept is answered
// at once with rejected set and sample 0. One sequencer drives a single shared
// 33x33 multiplier: 30 squaring steps for log2, two partial products for the ln
// scale, a 31-step bit-pair square root, the gain and angle products, 16 CORDIC
// rotations and the final sigma product. The time from acceptance to result of a
// first word is dominated by the log2 squaring loop and the square root. The
// phase quotient by 2^UNIFORM_BITS-1 is a sum of digit-shifted copies of the
// numerator plus one compare-and-increment fixup, overlapped with the log2 loop.
// in_ready is high only in idle; a finished result sits in the output register
// while the next word is taken. Configuration (mean, sigma) is always ready and
// should be written idle.
module box_muller_gaussian_generator
	import bmg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_word_t           in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output out_word_t          out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [15:0]        cfg_data
);

	bmg_state_t state_q, state_d;

	// control / register state
	logic               second_q;
	logic signed [15:0] cached_q;
	logic signed [15:0] mean_q;
	logic [15:0]        sigma_q;
	logic               out_valid_q;

	// datapath
	logic [4:0]                cnt_q;
	logic [UNIFORM_BITS-1:0]   un_q;
	logic [UNIFORM_BITS-1:0]   ang_q;
	logic [DivW-1:0]           quo_q;
	logic [ExpW-1:0]           exp_q;
	logic [30:0]               m_q;
	logic [29:0]               frac_q;
	logic [LogW-1:0]           d_q;
	logic [AccW-1:0]           acc_q;
	logic [SqW-1:0]            sq_rem_q;
	logic [SqW-1:0]            root_q;
	logic signed [CW-1:0]      x_q, y_q;
	logic signed [31:0]        z_q;
	logic [1:0]                quad_q;
	logic signed [15:0]        zn_q;
	logic signed [33:0]        sp_q;
	logic                      rej_q;
	out_word_t                 out_q;

	logic in_fire, out_free;
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// phase numerator: (u2 << 24) + floor(MaxU/2)
	logic [UNIFORM_BITS+24:0] num;
	assign num = {1'b0, ang_q, 24'b0} + (UNIFORM_BITS+25)'(MaxU >> 1);

	// msb search and normalize to Q1.30
	logic [ExpW-1:0]           msb;
	logic [UNIFORM_BITS+29:0]  norm_sh;
	always_comb begin
		msb = '0;
		for (int i = 0; i < UNIFORM_BITS; i++)
			if (un_q[i])
				msb = ExpW'(i);
	end
	assign norm_sh = {un_q, 30'b0} >> msb;

	// shared multiplier
	logic signed [MulW-1:0]  mul_a, mul_b;
	logic signed [ProdW-1:0] prod;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_LOG: begin
				mul_a = $signed(MulW'(m_q));
				mul_b = $signed(MulW'(m_q));
			end
			S_LN_LO: begin
				mul_a = $signed(MulW'(d_q[17:0]));
				mul_b = $signed(MulW'(LnK));
			end
			S_LN_HI: begin
				mul_a = $signed(MulW'(d_q[LogW-1:18]));
				mul_b = $signed(MulW'(LnK));
			end
			S_GAIN: begin
				mul_a = $signed(MulW'(root_q[RootW-1:0]));
				mul_b = $signed(MulW'(Gain));
			end
			S_ANGLE: begin
				mul_a = $signed(MulW'(quo_q[21:0]));
				mul_b = $signed(MulW'(TwoPi));
			end
			S_SCALE: begin
				mul_a = MulW'(zn_q);
				mul_b = $signed(MulW'(sigma_q));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	// log2 squaring step
	logic [31:0] sq;
	assign sq = prod[61:30];

	// phase quotient by MaxU = 2^UNIFORM_BITS-1: the sum of num >> k*UNIFORM_BITS,
	// shifted down, never overshoots and is at most one short
	logic [UNIFORM_BITS+25:0] psum;
	always_comb begin
		psum = '0;
		for (int k = 0; k * UNIFORM_BITS < UNIFORM_BITS + 25; k++)
			psum = psum + {1'b0, num >> (k * UNIFORM_BITS)};
	end

	// remainder of the estimate, num - quo*MaxU, in [0, 2*MaxU)
	logic [UNIFORM_BITS+25:0] pres;
	logic                     pge;
	assign pres = {1'b0, num} + (UNIFORM_BITS+26)'(quo_q)
		- {1'b0, quo_q, {UNIFORM_BITS{1'b0}}};
	assign pge  = pres >= (UNIFORM_BITS+26)'(MaxU);

	// log difference, clamped at zero
	logic [LogW-1:0] lu, dlog;
	assign lu   = {exp_q, frac_q};
	assign dlog = (lu > LogMax) ? '0 : LogMax - lu;

	// -2 ln u1 rounded to Q30, back in place as radicand
	logic [AccW-1:0] rnd_acc;
	assign rnd_acc = acc_q + (AccW'(1) << 25);

	// square root step
	logic [SqW-1:0] sbit;
	logic [SqW:0]   ssum;
	logic           sge;
	assign sbit = SqW'(1) << {cnt_q, 1'b0};
	assign ssum = {1'b0, root_q} + {1'b0, sbit};
	assign sge  = {1'b0, sq_rem_q} >= ssum;

	// gain and angle products, rounded
	logic signed [ProdW-1:0] gsum, asum;
	assign gsum = prod + (ProdW'(1) << 29);
	assign asum = prod + (ProdW'(1) << 23);

	// CORDIC step
	logic signed [CW-1:0] dx, dy;
	logic signed [31:0]   at;
	assign dx = y_q >>> cnt_q[3:0];
	assign dy = x_q >>> cnt_q[3:0];
	assign at = $signed({4'b0, atan_q28(cnt_q[3:0])});

	// quadrant fold
	logic signed [CW-1:0] cval, sval;
	always_comb begin
		case (quad_q)
			2'd0: begin
				cval = x_q;
				sval = y_q;
			end
			2'd1: begin
				cval = -y_q;
				sval = x_q;
			end
			2'd2: begin
				cval = -x_q;
				sval = -y_q;
			end
			default: begin
				cval = y_q;
				sval = -x_q;
			end
		endcase
	end

	logic signed [15:0] samp;
	assign samp = scale_sample(sp_q, mean_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (second_q)
						state_d = S_SCALE;
					else if (in_data.uniform_radius == '0)
						state_d = S_DONE;
					else
						state_d = S_NORM;
				end
			end
			S_NORM:    state_d = S_LOG;
			S_LOG:     if (cnt_q == 5'd29) state_d = S_DIFF;
			S_DIFF:    state_d = S_LN_LO;
			S_LN_LO:   state_d = S_LN_HI;
			S_LN_HI:   state_d = S_ROOT_LD;
			S_ROOT_LD: state_d = S_ROOT;
			S_ROOT:    if (cnt_q == 5'd0) state_d = S_GAIN;
			S_GAIN:    state_d = S_ANGLE;
			S_ANGLE:   state_d = S_ROTATE;
			S_ROTATE:  if (cnt_q == 5'd15) state_d = S_ROUND;
			S_ROUND:   state_d = S_SCALE;
			S_SCALE:   state_d = S_DONE;
			S_DONE:    if (out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// port outputs
	always_comb begin
		in_ready  = (state_q == S_IDLE);
		cfg_ready = 1'b1;
		out_valid = out_valid_q;
		out_data  = out_q;
	end

	// control state, pair cache and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			second_q    <= 1'b0;
			cached_q    <= '0;
			mean_q      <= '0;
			sigma_q     <= 16'd410;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && in_fire && second_q)
				second_q <= 1'b0;
			if (state_q == S_ROUND) begin
				second_q <= 1'b1;
				cached_q <= to_normal(sval);
			end
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MEAN:  mean_q  <= $signed(cfg_data);
					CFG_SCALE: sigma_q <= cfg_data;
					default:   ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					rej_q <= !second_q && (in_data.uniform_radius == '0);
					zn_q  <= cached_q;
					un_q  <= in_data.uniform_radius;
					ang_q <= in_data.uniform_angle;
				end
			end
			S_NORM: begin
				exp_q  <= msb;
				m_q    <= norm_sh[30:0];
				frac_q <= '0;
				cnt_q  <= '0;
				quo_q  <= psum[DivW+UNIFORM_BITS-1:UNIFORM_BITS];
			end
			S_LOG: begin
				m_q    <= sq[31] ? sq[31:1] : sq[30:0];
				frac_q <= {frac_q[28:0], sq[31]};
				if (cnt_q == 5'd0 && pge)
					quo_q <= quo_q + DivW'(1);
				cnt_q <= cnt_q + 5'd1;
			end
			S_DIFF:  d_q   <= dlog;
			S_LN_LO: acc_q <= prod[AccW-1:0];
			S_LN_HI: acc_q <= acc_q + {prod[AccW-19:0], 18'b0};
			S_ROOT_LD: begin
				sq_rem_q <= {rnd_acc[AccW-1:26], 26'b0};
				root_q   <= '0;
				cnt_q    <= 5'(SqrtSteps - 1);
			end
			S_ROOT: begin
				if (sge) begin
					sq_rem_q <= sq_rem_q - ssum[SqW-1:0];
					root_q   <= (root_q >> 1) + sbit;
				end else begin
					root_q <= root_q >> 1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
			S_GAIN: begin
				x_q <= gsum[CW+29:30];
				y_q <= '0;
			end
			S_ANGLE: begin
				z_q    <= asum[55:24];
				quad_q <= quo_q[23:22];
				cnt_q  <= '0;
			end
			S_ROTATE: begin
				if (!z_q[31]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
				cnt_q <= cnt_q + 5'd1;
			end
			S_ROUND: zn_q <= to_normal(cval);
			S_SCALE: sp_q <= prod[33:0];
			S_DONE: begin
				if (out_free) begin
					out_q.sample   <= rej_q ? '0 : samp;
					out_q.rejected <= rej_q;
				end
			end
			default: ;
		endcase
	end

endmodule
